[design/zbpa_pkg.sv]
// ---------------------------------------------------------------------------
// zbpa_pkg: shared types and constants of the zoned buddy page allocator
// Frame and list word layouts, item structs, codes and memory request types.
// ---------------------------------------------------------------------------
`default_nettype none

package zbpa_pkg;

   localparam int FRAME_BITS = 14;
   localparam int TOP_ORDER  = 10;
   localparam int NFR        = 1 << FRAME_BITS;
   localparam int LINK_W     = FRAME_BITS + 1;
   localparam int NORD       = TOP_ORDER + 1;
   localparam int NLISTS     = 3 * NORD;
   localparam int LIST_AW    = $clog2(NLISTS);
   localparam int ORDER_W    = 4;
   localparam int ZONE_W     = 2;
   localparam int CFG_W      = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int STATUS_W   = 3;

   // empty list / end of list marker
   localparam logic [LINK_W-1:0] NIL = LINK_W'(1) << FRAME_BITS;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DMA_LIMIT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DMA32_BASE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DMA32_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_BASE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_LIMIT = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] RS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] RS_NOMEM   = 3'd1;
   localparam logic [STATUS_W-1:0] RS_BADZONE = 3'd2;
   localparam logic [STATUS_W-1:0] RS_ORDER   = 3'd3;
   localparam logic [STATUS_W-1:0] RS_OUTSIDE = 3'd4;

   // frame status codes
   localparam logic [1:0] FS_INVALID = 2'd0;
   localparam logic [1:0] FS_FREE    = 2'd1;
   localparam logic [1:0] FS_SPLIT   = 2'd2;
   localparam logic [1:0] FS_ALLOC   = 2'd3;

   localparam logic [ZONE_W-1:0] ZONE_DMA    = 2'd0;
   localparam logic [ZONE_W-1:0] ZONE_DMA32  = 2'd1;
   localparam logic [ZONE_W-1:0] ZONE_NORMAL = 2'd2;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef struct packed {
      logic                  mode;
      logic [ZONE_W-1:0]     zone_select;
      logic [ORDER_W-1:0]    block_order;
      logic [FRAME_BITS-1:0] page_frame;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [FRAME_BITS-1:0] granted_frame;
      logic [ZONE_W-1:0]     zone_served;
   } rsp_item_type;

   // per frame metadata and links
   typedef struct packed {
      logic [1:0]         status;
      logic [ORDER_W-1:0] order;
      logic [ZONE_W-1:0]  zone;
      logic [LINK_W-1:0]  prev;
      logic [LINK_W-1:0]  next;
   } frame_word_type;

   typedef struct packed {
      logic [LINK_W-1:0] head;
      logic [LINK_W-1:0] tail;
   } list_word_type;

   typedef struct packed {
      logic                  we;
      logic [FRAME_BITS-1:0] waddr;
      frame_word_type        wdata;
      logic                  re;
      logic [FRAME_BITS-1:0] raddr;
   } frame_req_type;

   typedef struct packed {
      logic               we;
      logic [LIST_AW-1:0] waddr;
      list_word_type      wdata;
      logic               re;
      logic [LIST_AW-1:0] raddr;
   } list_req_type;

   typedef struct packed {
      logic              hit;
      logic [ZONE_W-1:0] zone;
   } zone_hit_type;

   function automatic logic [LIST_AW-1:0] list_index(input logic [ZONE_W-1:0] zone,
                                                     input logic [ORDER_W-1:0] order);
      list_index = LIST_AW'(zone) * LIST_AW'(NORD) + LIST_AW'(order);
   endfunction

endpackage

`default_nettype wire

[design/zbpa_ram.sv]
// ---------------------------------------------------------------------------
// zbpa_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module zbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

[design/zbpa_csr.sv]
// ---------------------------------------------------------------------------
// zbpa_csr: zone bound registers and zone lookup
// Holds the five bound registers and maps a page frame onto its zone.
// ---------------------------------------------------------------------------
`default_nettype none

module zbpa_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [zbpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [zbpa_pkg::CFG_W-1:0]       csr_wdata,
   input  wire logic [zbpa_pkg::FRAME_BITS-1:0]  frame,
   output      zbpa_pkg::zone_hit_type           zone_hit
);

   logic [zbpa_pkg::CFG_W-1:0] dma_limit_ff;
   logic [zbpa_pkg::CFG_W-1:0] dma32_base_ff;
   logic [zbpa_pkg::CFG_W-1:0] dma32_limit_ff;
   logic [zbpa_pkg::CFG_W-1:0] normal_base_ff;
   logic [zbpa_pkg::CFG_W-1:0] normal_limit_ff;
   logic [zbpa_pkg::CFG_W-1:0] frame_ext;

   assign csr_ready = 1'b1;
   assign frame_ext = zbpa_pkg::CFG_W'(frame);

   always_ff @(posedge clock) begin
      if (reset) begin
         dma_limit_ff    <= 15'd4096;
         dma32_base_ff   <= 15'd4096;
         dma32_limit_ff  <= 15'd16384;
         normal_base_ff  <= 15'd16384;
         normal_limit_ff <= 15'd16384;
      end else if (csr_valid) begin
         unique case (csr_index)
            zbpa_pkg::CSR_DMA_LIMIT:    dma_limit_ff    <= csr_wdata;
            zbpa_pkg::CSR_DMA32_BASE:   dma32_base_ff   <= csr_wdata;
            zbpa_pkg::CSR_DMA32_LIMIT:  dma32_limit_ff  <= csr_wdata;
            zbpa_pkg::CSR_NORMAL_BASE:  normal_base_ff  <= csr_wdata;
            zbpa_pkg::CSR_NORMAL_LIMIT: normal_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      zone_hit.hit  = 1'b1;
      zone_hit.zone = zbpa_pkg::ZONE_DMA;
      priority if (frame_ext < dma_limit_ff) begin
         zone_hit.zone = zbpa_pkg::ZONE_DMA;
      end else if (frame_ext >= dma32_base_ff && frame_ext < dma32_limit_ff) begin
         zone_hit.zone = zbpa_pkg::ZONE_DMA32;
      end else if (frame_ext >= normal_base_ff && frame_ext < normal_limit_ff) begin
         zone_hit.zone = zbpa_pkg::ZONE_NORMAL;
      end else begin
         zone_hit.hit = 1'b0;
      end
   end

endmodule

`default_nettype wire

[design/zbpa_ctrl.sv]
// ---------------------------------------------------------------------------
// zbpa_ctrl: allocator sequencer
// Walks the free lists, splits and coalesces blocks by read-modify-write on
// the frame memory and the list memory; clears both after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module zbpa_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output      logic                            busy,
   input  wire zbpa_pkg::req_item_type          req_item,
   input  wire zbpa_pkg::zone_hit_type          zone_hit,
   output      logic                            rsp_strobe,
   output      zbpa_pkg::rsp_item_type          rsp_item,
   output      zbpa_pkg::frame_req_type         frame_req,
   input  wire zbpa_pkg::frame_word_type        frame_rdata,
   output      zbpa_pkg::list_req_type          list_req,
   input  wire zbpa_pkg::list_word_type         list_rdata
);

   localparam int FB = zbpa_pkg::FRAME_BITS;
   localparam int OW = zbpa_pkg::ORDER_W;
   localparam int ZW = zbpa_pkg::ZONE_W;
   localparam int LW = zbpa_pkg::LINK_W;
   localparam int AW = zbpa_pkg::LIST_AW;
   localparam int SW = 5;

   localparam logic [SW-1:0] S_CLR   = 5'd0;
   localparam logic [SW-1:0] S_IDLE  = 5'd1;
   localparam logic [SW-1:0] S_A_LR  = 5'd2;
   localparam logic [SW-1:0] S_A_LC  = 5'd3;
   localparam logic [SW-1:0] S_A_SPL = 5'd4;
   localparam logic [SW-1:0] S_A_FIN = 5'd5;
   localparam logic [SW-1:0] S_F_CHK = 5'd6;
   localparam logic [SW-1:0] S_F_B   = 5'd7;
   localparam logic [SW-1:0] S_F_UB  = 5'd8;
   localparam logic [SW-1:0] S_F_MX  = 5'd9;
   localparam logic [SW-1:0] S_F_MB  = 5'd10;
   localparam logic [SW-1:0] S_U_RD  = 5'd11;
   localparam logic [SW-1:0] S_U_GET = 5'd12;
   localparam logic [SW-1:0] S_U_P   = 5'd13;
   localparam logic [SW-1:0] S_U_PW  = 5'd14;
   localparam logic [SW-1:0] S_U_HW  = 5'd15;
   localparam logic [SW-1:0] S_U_N   = 5'd16;
   localparam logic [SW-1:0] S_U_NW  = 5'd17;
   localparam logic [SW-1:0] S_U_TW  = 5'd18;
   localparam logic [SW-1:0] S_P_RD  = 5'd19;
   localparam logic [SW-1:0] S_P_CHK = 5'd20;
   localparam logic [SW-1:0] S_P_LR  = 5'd21;
   localparam logic [SW-1:0] S_P_T   = 5'd22;
   localparam logic [SW-1:0] S_P_TR  = 5'd23;
   localparam logic [SW-1:0] S_P_TW  = 5'd24;
   localparam logic [SW-1:0] S_P_LW  = 5'd25;

   localparam logic [OW-1:0] TOP = OW'(zbpa_pkg::TOP_ORDER);

   logic [SW-1:0] state_ff, state_in;
   logic [FB-1:0] clr_ff, clr_in;
   // allocation walk
   logic [OW-1:0] aord_ff, aord_in;
   logic [ZW-1:0] cz_ff, cz_in;
   logic [OW-1:0] ci_ff, ci_in;
   logic [FB-1:0] pg_ff, pg_in;
   logic [OW-1:0] cur_ff, cur_in;
   // free walk
   logic [FB-1:0] fx_ff, fx_in;
   logic [OW-1:0] ford_ff, ford_in;
   logic [ZW-1:0] fz_ff, fz_in;
   logic [FB-1:0] fb_ff, fb_in;
   // unlink routine
   logic [FB-1:0] ux_ff, ux_in;
   logic [SW-1:0] uret_ff, uret_in;
   logic [LW-1:0] up_ff, up_in;
   logic [LW-1:0] un_ff, un_in;
   logic [AW-1:0] ul_ff, ul_in;
   // put-free routine
   logic [FB-1:0] px_ff, px_in;
   logic [OW-1:0] pord_ff, pord_in;
   logic [ZW-1:0] pz_ff, pz_in;
   logic [SW-1:0] pret_ff, pret_in;
   logic [LW-1:0] pt_ff, pt_in;
   logic [LW-1:0] plh_ff, plh_in;
   // result
   logic                   rsp_valid_ff, rsp_valid_in;
   zbpa_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic [FB-1:0] split_frame;
   logic [FB-1:0] buddy_frame;
   logic [FB-1:0] merged_frame;
   logic [AW-1:0] put_list;

   assign split_frame  = pg_ff + (FB'(1) << (cur_ff - OW'(1)));
   assign buddy_frame  = fx_ff ^ (FB'(1) << ford_ff);
   assign merged_frame = fx_ff & ~((FB'(2) << ford_ff) - FB'(1));
   assign put_list     = zbpa_pkg::list_index(pz_ff, pord_ff);

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      aord_ff     <= aord_in;
      cz_ff       <= cz_in;
      ci_ff       <= ci_in;
      pg_ff       <= pg_in;
      cur_ff      <= cur_in;
      fx_ff       <= fx_in;
      ford_ff     <= ford_in;
      fz_ff       <= fz_in;
      fb_ff       <= fb_in;
      ux_ff       <= ux_in;
      uret_ff     <= uret_in;
      up_ff       <= up_in;
      un_ff       <= un_in;
      ul_ff       <= ul_in;
      px_ff       <= px_in;
      pord_ff     <= pord_in;
      pz_ff       <= pz_in;
      pret_ff     <= pret_in;
      pt_ff       <= pt_in;
      plh_ff      <= plh_in;
      rsp_item_ff <= rsp_item_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      aord_in      = aord_ff;
      cz_in        = cz_ff;
      ci_in        = ci_ff;
      pg_in        = pg_ff;
      cur_in       = cur_ff;
      fx_in        = fx_ff;
      ford_in      = ford_ff;
      fz_in        = fz_ff;
      fb_in        = fb_ff;
      ux_in        = ux_ff;
      uret_in      = uret_ff;
      up_in        = up_ff;
      un_in        = un_ff;
      ul_in        = ul_ff;
      px_in        = px_ff;
      pord_in      = pord_ff;
      pz_in        = pz_ff;
      pret_in      = pret_ff;
      pt_in        = pt_ff;
      plh_in       = plh_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      frame_req    = '0;
      list_req     = '0;

      unique case (state_ff)
         S_CLR: begin
            frame_req.we    = 1'b1;
            frame_req.waddr = clr_ff;
            if (clr_ff < FB'(zbpa_pkg::NLISTS)) begin
               list_req.we         = 1'b1;
               list_req.waddr      = clr_ff[AW-1:0];
               list_req.wdata.head = zbpa_pkg::NIL;
               list_req.wdata.tail = zbpa_pkg::NIL;
            end
            clr_in = clr_ff + FB'(1);
            if (clr_ff == {FB{1'b1}}) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               rsp_item_in = '0;
               if (req_item.mode == zbpa_pkg::MODE_ALLOC) begin
                  priority if (req_item.zone_select > zbpa_pkg::ZONE_NORMAL) begin
                     rsp_valid_in       = 1'b1;
                     rsp_item_in.status = zbpa_pkg::RS_BADZONE;
                  end else if (req_item.block_order > TOP) begin
                     rsp_valid_in       = 1'b1;
                     rsp_item_in.status = zbpa_pkg::RS_ORDER;
                  end else begin
                     cz_in    = req_item.zone_select;
                     ci_in    = req_item.block_order;
                     aord_in  = req_item.block_order;
                     state_in = S_A_LR;
                  end
               end else begin
                  priority if (!zone_hit.hit) begin
                     rsp_valid_in       = 1'b1;
                     rsp_item_in.status = zbpa_pkg::RS_OUTSIDE;
                  end else if (req_item.block_order > TOP) begin
                     rsp_valid_in            = 1'b1;
                     rsp_item_in.status      = zbpa_pkg::RS_ORDER;
                     rsp_item_in.zone_served = zone_hit.zone;
                  end else begin
                     fx_in    = req_item.page_frame;
                     ford_in  = req_item.block_order;
                     fz_in    = zone_hit.zone;
                     px_in    = req_item.page_frame;
                     pord_in  = req_item.block_order;
                     pz_in    = zone_hit.zone;
                     pret_in  = S_F_CHK;
                     state_in = S_P_RD;
                  end
               end
            end
         end

         // ---- allocation ----
         S_A_LR: begin
            list_req.re    = 1'b1;
            list_req.raddr = zbpa_pkg::list_index(cz_ff, ci_ff);
            state_in       = S_A_LC;
         end

         S_A_LC: begin
            priority if (list_rdata.head < zbpa_pkg::NIL) begin
               pg_in    = list_rdata.head[FB-1:0];
               ux_in    = list_rdata.head[FB-1:0];
               cur_in   = ci_ff;
               uret_in  = S_A_SPL;
               state_in = S_U_RD;
            end else if (ci_ff < TOP) begin
               ci_in    = ci_ff + OW'(1);
               state_in = S_A_LR;
            end else if (cz_ff != zbpa_pkg::ZONE_DMA) begin
               cz_in    = cz_ff - ZW'(1);
               ci_in    = aord_ff;
               state_in = S_A_LR;
            end else begin
               rsp_valid_in       = 1'b1;
               rsp_item_in.status = zbpa_pkg::RS_NOMEM;
               state_in           = S_IDLE;
            end
         end

         // split off the right half at each level down to the asked order
         S_A_SPL: begin
            if (cur_ff > aord_ff) begin
               cur_in = cur_ff - OW'(1);
               if (split_frame != pg_ff) begin
                  px_in    = split_frame;
                  pord_in  = cur_ff - OW'(1);
                  pz_in    = cz_ff;
                  pret_in  = S_A_SPL;
                  state_in = S_P_RD;
               end
            end else begin
               state_in = S_A_FIN;
            end
         end

         S_A_FIN: begin
            frame_req.we           = 1'b1;
            frame_req.waddr        = pg_ff;
            frame_req.wdata.status = zbpa_pkg::FS_ALLOC;
            frame_req.wdata.order  = aord_ff;
            frame_req.wdata.zone   = cz_ff;
            rsp_valid_in              = 1'b1;
            rsp_item_in.status        = zbpa_pkg::RS_OK;
            rsp_item_in.granted_frame = pg_ff;
            rsp_item_in.zone_served   = cz_ff;
            state_in                  = S_IDLE;
         end

         // ---- free and coalesce ----
         S_F_CHK: begin
            fb_in = buddy_frame;
            if (ford_ff >= TOP || buddy_frame == fx_ff) begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.status      = zbpa_pkg::RS_OK;
               rsp_item_in.zone_served = fz_ff;
               state_in                = S_IDLE;
            end else begin
               frame_req.re    = 1'b1;
               frame_req.raddr = buddy_frame;
               state_in        = S_F_B;
            end
         end

         S_F_B: begin
            if (frame_rdata.status == zbpa_pkg::FS_FREE && frame_rdata.order == ford_ff) begin
               ux_in    = fx_ff;
               uret_in  = S_F_UB;
               state_in = S_U_RD;
            end else begin
               rsp_valid_in            = 1'b1;
               rsp_item_in.status      = zbpa_pkg::RS_OK;
               rsp_item_in.zone_served = fz_ff;
               state_in                = S_IDLE;
            end
         end

         S_F_UB: begin
            ux_in    = fb_ff;
            uret_in  = S_F_MX;
            state_in = S_U_RD;
         end

         S_F_MX: begin
            frame_req.we    = 1'b1;
            frame_req.waddr = fx_ff;
            state_in        = S_F_MB;
         end

         S_F_MB: begin
            frame_req.we    = 1'b1;
            frame_req.waddr = fb_ff;
            fx_in           = merged_frame;
            ford_in         = ford_ff + OW'(1);
            px_in           = merged_frame;
            pord_in         = ford_ff + OW'(1);
            pz_in           = fz_ff;
            pret_in         = S_F_CHK;
            state_in        = S_P_RD;
         end

         // ---- unlink ux from its list ----
         S_U_RD: begin
            frame_req.re    = 1'b1;
            frame_req.raddr = ux_ff;
            state_in        = S_U_GET;
         end

         S_U_GET: begin
            up_in    = frame_rdata.prev;
            un_in    = frame_rdata.next;
            ul_in    = zbpa_pkg::list_index(frame_rdata.zone, frame_rdata.order);
            state_in = S_U_P;
         end

         S_U_P: begin
            if (up_ff < zbpa_pkg::NIL) begin
               frame_req.re    = 1'b1;
               frame_req.raddr = up_ff[FB-1:0];
               state_in        = S_U_PW;
            end else begin
               list_req.re    = 1'b1;
               list_req.raddr = ul_ff;
               state_in       = S_U_HW;
            end
         end

         S_U_PW: begin
            frame_req.we         = 1'b1;
            frame_req.waddr      = up_ff[FB-1:0];
            frame_req.wdata      = frame_rdata;
            frame_req.wdata.next = un_ff;
            state_in             = S_U_N;
         end

         S_U_HW: begin
            list_req.we         = 1'b1;
            list_req.waddr      = ul_ff;
            list_req.wdata      = list_rdata;
            list_req.wdata.head = un_ff;
            state_in            = S_U_N;
         end

         S_U_N: begin
            if (un_ff < zbpa_pkg::NIL) begin
               frame_req.re    = 1'b1;
               frame_req.raddr = un_ff[FB-1:0];
               state_in        = S_U_NW;
            end else begin
               list_req.re    = 1'b1;
               list_req.raddr = ul_ff;
               state_in       = S_U_TW;
            end
         end

         S_U_NW: begin
            frame_req.we         = 1'b1;
            frame_req.waddr      = un_ff[FB-1:0];
            frame_req.wdata      = frame_rdata;
            frame_req.wdata.prev = up_ff;
            state_in             = uret_ff;
         end

         S_U_TW: begin
            list_req.we         = 1'b1;
            list_req.waddr      = ul_ff;
            list_req.wdata      = list_rdata;
            list_req.wdata.tail = up_ff;
            state_in            = uret_ff;
         end

         // ---- put px on the tail of its list ----
         S_P_RD: begin
            frame_req.re    = 1'b1;
            frame_req.raddr = px_ff;
            state_in        = S_P_CHK;
         end

         S_P_CHK: begin
            if (frame_rdata.status == zbpa_pkg::FS_FREE) begin
               ux_in    = px_ff;
               uret_in  = S_P_LR;
               state_in = S_U_RD;
            end else begin
               state_in = S_P_LR;
            end
         end

         S_P_LR: begin
            list_req.re    = 1'b1;
            list_req.raddr = put_list;
            state_in       = S_P_T;
         end

         S_P_T: begin
            pt_in                  = list_rdata.tail;
            plh_in                 = list_rdata.head;
            frame_req.we           = 1'b1;
            frame_req.waddr        = px_ff;
            frame_req.wdata.status = zbpa_pkg::FS_FREE;
            frame_req.wdata.order  = pord_ff;
            frame_req.wdata.zone   = pz_ff;
            frame_req.wdata.prev   = list_rdata.tail;
            frame_req.wdata.next   = zbpa_pkg::NIL;
            state_in = (list_rdata.tail < zbpa_pkg::NIL) ? S_P_TR : S_P_LW;
         end

         S_P_TR: begin
            frame_req.re    = 1'b1;
            frame_req.raddr = pt_ff[FB-1:0];
            state_in        = S_P_TW;
         end

         S_P_TW: begin
            frame_req.we         = 1'b1;
            frame_req.waddr      = pt_ff[FB-1:0];
            frame_req.wdata      = frame_rdata;
            frame_req.wdata.next = LW'(px_ff);
            state_in             = S_P_LW;
         end

         S_P_LW: begin
            list_req.we         = 1'b1;
            list_req.waddr      = put_list;
            list_req.wdata.head = (pt_ff < zbpa_pkg::NIL) ? plh_ff : LW'(px_ff);
            list_req.wdata.tail = LW'(px_ff);
            state_in            = pret_ff;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[design/zoned_buddy_page_allocator_unit.sv]
// ---------------------------------------------------------------------------
// zoned_buddy_page_allocator_unit: zoned buddy page allocator, top level
// Three zones, FIFO free list per order, links kept in a frame memory.
//
//   channel  ports                                       direction
//   req      start, busy, req_item                       in  (taken on start & !busy)
//   rsp      rsp_strobe, rsp_item                        out (one cycle strobe)
//   csr      csr_valid, csr_ready, csr_index, csr_wdata  in  (zone bounds)
//
// Each item runs through a sequencer over the frame memory and the list
// memory, one access per memory per cycle. A rejected item strobes its result
// in the cycle after it is taken and busy stays low. An unlink reads the
// frame word and relinks its neighbours or the list ends; an append unlinks
// a frame that was free, links it after the list tail and writes the list
// word. An allocation probes lists, unlinks and splits; a free appends and
// merges per coalesce level. Busy is high while the memories clear after
// reset. Results cannot be held off by the receiver.
// ---------------------------------------------------------------------------
`default_nettype none

module zoned_buddy_page_allocator_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output      logic                             busy,
   input  wire zbpa_pkg::req_item_type           req_item,
   output      logic                             rsp_strobe,
   output      zbpa_pkg::rsp_item_type           rsp_item,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [zbpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [zbpa_pkg::CFG_W-1:0]       csr_wdata
);

   zbpa_pkg::zone_hit_type   zone_hit;
   zbpa_pkg::frame_req_type  frame_req;
   zbpa_pkg::frame_word_type frame_rdata;
   zbpa_pkg::list_req_type   list_req;
   zbpa_pkg::list_word_type  list_rdata;

   zbpa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .frame     (req_item.page_frame),
      .zone_hit  (zone_hit)
   );

   zbpa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .zone_hit    (zone_hit),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .frame_req   (frame_req),
      .frame_rdata (frame_rdata),
      .list_req    (list_req),
      .list_rdata  (list_rdata)
   );

   zbpa_ram #(
      .WIDTH ($bits(zbpa_pkg::frame_word_type)),
      .DEPTH (zbpa_pkg::NFR)
   ) u_frame_ram (
      .clock (clock),
      .we    (frame_req.we),
      .waddr (frame_req.waddr),
      .wdata (frame_req.wdata),
      .re    (frame_req.re),
      .raddr (frame_req.raddr),
      .rdata (frame_rdata)
   );

   zbpa_ram #(
      .WIDTH ($bits(zbpa_pkg::list_word_type)),
      .DEPTH (zbpa_pkg::NLISTS)
   ) u_list_ram (
      .clock (clock),
      .we    (list_req.we),
      .waddr (list_req.waddr),
      .wdata (list_req.wdata),
      .re    (list_req.re),
      .raddr (list_req.raddr),
      .rdata (list_rdata)
   );

endmodule

`default_nettype wire

[verif/zoned_buddy_page_allocator_unit_tb.sv]
// ---------------------------------------------------------------------------
// zoned_buddy_page_allocator_unit_tb: self-checking testbench of the allocator
// A scoreboard copy of the zone free lists predicts every result as each item
// is queued. A driver and a monitor run the handshakes. Zone bounds change
// between phases, and random gaps are placed on the request side.
// ---------------------------------------------------------------------------
module zoned_buddy_page_allocator_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int NFR         = zbpa_pkg::NFR;
   localparam int NLISTS      = zbpa_pkg::NLISTS;
   localparam int NORD        = zbpa_pkg::NORD;
   localparam int TOP_ORDER   = zbpa_pkg::TOP_ORDER;
   localparam int FMASK       = NFR - 1;
   localparam int ZW          = zbpa_pkg::ZONE_W;
   localparam int OW          = zbpa_pkg::ORDER_W;
   localparam int FB          = zbpa_pkg::FRAME_BITS;
   localparam int CW          = zbpa_pkg::CFG_W;
   localparam int IW          = zbpa_pkg::CSR_IDX_W;

   typedef struct {
      int frame;
      int order;
   } granted_block_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   zbpa_pkg::req_item_type req_item = '0;
   logic                   rsp_strobe;
   zbpa_pkg::rsp_item_type rsp_item;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [IW-1:0]          csr_index = '0;
   logic [CW-1:0]          csr_wdata = '0;

   zoned_buddy_page_allocator_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // scoreboard copy of the frame metadata and free lists
   logic [1:0]    sb_status [NFR];
   logic [OW-1:0] sb_order  [NFR];
   int            sb_next   [NFR];
   int            sb_prev   [NFR];
   int            sb_head   [NLISTS];
   int            sb_tail   [NLISTS];
   int            zone_bound [5];

   zbpa_pkg::req_item_type pending_reqs [$];
   zbpa_pkg::rsp_item_type awaited_rsps [$];
   granted_block_type      granted [$];
   int                     err_count = 0;
   int                     cycle_count = 0;

   function automatic void unlink_frame(int x);
      int p, n;
      p = sb_prev[x];
      n = sb_next[x];
      if (p < NFR) sb_next[p] = n;
      else
         for (int l = 0; l < NLISTS; l++)
            if (sb_head[l] == x) begin
               sb_head[l] = n;
               break;
            end
      if (n < NFR) sb_prev[n] = p;
      else
         for (int l = 0; l < NLISTS; l++)
            if (sb_tail[l] == x) begin
               sb_tail[l] = p;
               break;
            end
   endfunction

   function automatic void put_free(int zone, int x, int ord);
      int l, t;
      if (sb_status[x] == zbpa_pkg::FS_FREE) unlink_frame(x);
      sb_status[x] = zbpa_pkg::FS_FREE;
      sb_order[x]  = OW'(ord);
      l = zone * NORD + ord;
      t = sb_tail[l];
      sb_prev[x] = t;
      sb_next[x] = NFR;
      if (t < NFR) sb_next[t] = x;
      else sb_head[l] = x;
      sb_tail[l] = x;
   endfunction

   function automatic zbpa_pkg::rsp_item_type predict_alloc(int zsel, int ord);
      zbpa_pkg::rsp_item_type r;
      int l, pg, right;
      r = '0;
      if (zsel > int'(zbpa_pkg::ZONE_NORMAL)) begin
         r.status = zbpa_pkg::RS_BADZONE;
         return r;
      end
      if (ord > TOP_ORDER) begin
         r.status = zbpa_pkg::RS_ORDER;
         return r;
      end
      for (int z = zsel; z >= 0; z--)
         for (int i = ord; i <= TOP_ORDER; i++) begin
            l = z * NORD + i;
            // stale entries at the head are dropped
            while (sb_head[l] < NFR && sb_status[sb_head[l]] != zbpa_pkg::FS_FREE)
               unlink_frame(sb_head[l]);
            pg = sb_head[l];
            if (pg >= NFR) continue;
            unlink_frame(pg);
            sb_status[pg] = zbpa_pkg::FS_SPLIT;
            for (int cur = i; cur > ord; cur--) begin
               right = (pg + (1 << (cur - 1))) & FMASK;
               sb_order[pg] = OW'(cur - 1);
               if (right != pg) put_free(z, right, cur - 1);
            end
            sb_status[pg] = zbpa_pkg::FS_ALLOC;
            sb_order[pg]  = OW'(ord);
            r.status        = zbpa_pkg::RS_OK;
            r.granted_frame = FB'(pg);
            r.zone_served   = ZW'(z);
            return r;
         end
      r.status = zbpa_pkg::RS_NOMEM;
      return r;
   endfunction

   function automatic zbpa_pkg::rsp_item_type predict_free(int pfn, int ord);
      zbpa_pkg::rsp_item_type r;
      int z, x, b;
      r = '0;
      x = pfn & FMASK;
      if (x < zone_bound[0]) z = 0;
      else if (x >= zone_bound[1] && x < zone_bound[2]) z = 1;
      else if (x >= zone_bound[3] && x < zone_bound[4]) z = 2;
      else begin
         r.status = zbpa_pkg::RS_OUTSIDE;
         return r;
      end
      r.zone_served = ZW'(z);
      if (ord > TOP_ORDER) begin
         r.status = zbpa_pkg::RS_ORDER;
         return r;
      end
      forever begin
         put_free(z, x, ord);
         if (ord >= TOP_ORDER) break;
         b = (x ^ (1 << ord)) & FMASK;
         if (b == x || sb_status[b] != zbpa_pkg::FS_FREE || int'(sb_order[b]) != ord) break;
         unlink_frame(x);
         unlink_frame(b);
         sb_status[x] = zbpa_pkg::FS_INVALID;
         sb_status[b] = zbpa_pkg::FS_INVALID;
         x = x & ~((2 << ord) - 1) & FMASK;
         ord++;
      end
      r.status = zbpa_pkg::RS_OK;
      return r;
   endfunction

   task automatic queue_item(logic mode, int zsel, int ord, int pfn);
      zbpa_pkg::req_item_type q;
      zbpa_pkg::rsp_item_type r;
      granted_block_type g;
      q.mode        = mode;
      q.zone_select = ZW'(zsel);
      q.block_order = OW'(ord);
      q.page_frame  = FB'(pfn);
      if (mode == zbpa_pkg::MODE_ALLOC) r = predict_alloc(zsel, ord);
      else r = predict_free(pfn, ord);
      if (mode == zbpa_pkg::MODE_ALLOC && r.status == zbpa_pkg::RS_OK) begin
         g.frame = int'(r.granted_frame);
         g.order = ord;
         granted.push_back(g);
      end
      awaited_rsps.push_back(r);
      pending_reqs.push_back(q);
   endtask

   function automatic int pick_order();
      int w;
      w = $urandom_range(0, 99);
      if (w < 70) return $urandom_range(0, 3);
      if (w < 95) return $urandom_range(4, TOP_ORDER);
      return $urandom_range(TOP_ORDER + 1, 15);
   endfunction

   task automatic queue_random_item();
      int w, ord, idx;
      w = $urandom_range(0, 99);
      if (w < 45) begin
         queue_item(zbpa_pkg::MODE_ALLOC,
                    ($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2),
                    pick_order(), $urandom_range(0, FMASK));
      end else if (w < 80 && granted.size() > 0) begin
         idx = $urandom_range(0, granted.size() - 1);
         queue_item(zbpa_pkg::MODE_FREE, $urandom_range(0, 3), granted[idx].order,
                    granted[idx].frame);
         granted.delete(idx);
      end else if (w < 92) begin
         // aligned block, often large to refill the lists
         ord = ($urandom_range(0, 2) == 0) ? TOP_ORDER : $urandom_range(0, TOP_ORDER);
         queue_item(zbpa_pkg::MODE_FREE, $urandom_range(0, 3), ord,
                    $urandom_range(0, FMASK) & ~((1 << ord) - 1));
      end else begin
         queue_item(1'($urandom_range(0, 1)), $urandom_range(0, 3), $urandom_range(0, 15),
                    $urandom_range(0, FMASK));
      end
   endtask

   task automatic write_bound(logic [IW-1:0] idx, int val);
      csr_index <= idx;
      csr_wdata <= CW'(val);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      zone_bound[idx] = val;
   endtask

   task automatic set_bounds(int a, int b, int c, int d, int e);
      write_bound(zbpa_pkg::CSR_DMA_LIMIT, a);
      write_bound(zbpa_pkg::CSR_DMA32_BASE, b);
      write_bound(zbpa_pkg::CSR_DMA32_LIMIT, c);
      write_bound(zbpa_pkg::CSR_NORMAL_BASE, d);
      write_bound(zbpa_pkg::CSR_NORMAL_LIMIT, e);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || awaited_rsps.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_random(int n);
      repeat (n) queue_random_item();
      wait_drained();
   endtask

   task automatic report_mismatch(string what, int got, int exp_val);
      $display("mismatch %s: got %0d expected %0d at cycle %0d",
               what, got, exp_val, cycle_count);
      err_count++;
   endtask

   // request driver
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         void'(pending_reqs.pop_front());
         case ($urandom_range(0, 19))
            0:       gap_left = $urandom_range(20, 60);
            1, 2, 3: gap_left = $urandom_range(3, 10);
            default: gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 2);
         endcase
         if (gap_left == 0 && pending_reqs.size() > 0) begin
            req_item <= pending_reqs[0];
         end else begin
            start <= 1'b0;
         end
      end else if (!start) begin
         if (gap_left > 0) gap_left--;
         else if (pending_reqs.size() > 0) begin
            start    <= 1'b1;
            req_item <= pending_reqs[0];
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      zbpa_pkg::rsp_item_type e;
      if (!reset && rsp_strobe) begin
         if (awaited_rsps.size() == 0) begin
            report_mismatch("unexpected result, status", int'(rsp_item.status), -1);
         end else begin
            e = awaited_rsps.pop_front();
            if (rsp_item.status != e.status)
               report_mismatch("status", int'(rsp_item.status), int'(e.status));
            if (rsp_item.granted_frame != e.granted_frame)
               report_mismatch("granted_frame", int'(rsp_item.granted_frame),
                               int'(e.granted_frame));
            if (rsp_item.zone_served != e.zone_served)
               report_mismatch("zone_served", int'(rsp_item.zone_served),
                               int'(e.zone_served));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NFR; i++) begin
         sb_status[i] = zbpa_pkg::FS_INVALID;
         sb_order[i]  = '0;
         sb_next[i]   = 0;
         sb_prev[i]   = 0;
      end
      for (int l = 0; l < NLISTS; l++) begin
         sb_head[l] = NFR;
         sb_tail[l] = NFR;
      end
      zone_bound = '{4096, 4096, 16384, 16384, 16384};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_bounds(4096, 4096, 16384, 16384, 16384);
      // directed: seed lists, fallback, rejects, odd frees
      queue_item(zbpa_pkg::MODE_FREE, 0, TOP_ORDER, 0);
      queue_item(zbpa_pkg::MODE_FREE, 0, TOP_ORDER, 1024);
      queue_item(zbpa_pkg::MODE_FREE, 0, TOP_ORDER, 4096);
      queue_item(zbpa_pkg::MODE_FREE, 0, TOP_ORDER, 8192);
      queue_item(zbpa_pkg::MODE_ALLOC, 0, 0, 0);
      queue_item(zbpa_pkg::MODE_ALLOC, 2, 0, 0);
      queue_item(zbpa_pkg::MODE_ALLOC, 1, TOP_ORDER, 0);
      queue_item(zbpa_pkg::MODE_ALLOC, 1, TOP_ORDER, 0);
      queue_item(zbpa_pkg::MODE_ALLOC, 3, 0, 0);
      queue_item(zbpa_pkg::MODE_ALLOC, 0, TOP_ORDER + 1, 0);
      queue_item(zbpa_pkg::MODE_ALLOC, 2, 15, 0);
      queue_item(zbpa_pkg::MODE_FREE, 0, TOP_ORDER + 1, 0);
      queue_item(zbpa_pkg::MODE_FREE, 3, 15, FMASK);
      queue_item(zbpa_pkg::MODE_FREE, 0, 0, FMASK);
      queue_item(zbpa_pkg::MODE_FREE, 0, 0, FMASK);
      queue_item(zbpa_pkg::MODE_FREE, 0, 2, 3);
      queue_item(zbpa_pkg::MODE_FREE, 0, 0, 1);
      queue_item(zbpa_pkg::MODE_ALLOC, 0, 3, 0);
      queue_item(zbpa_pkg::MODE_ALLOC, 1, 0, 0);
      queue_item(zbpa_pkg::MODE_ALLOC, 0, TOP_ORDER, 0);
      queue_item(zbpa_pkg::MODE_ALLOC, 0, TOP_ORDER, 0);
      wait_drained();
      run_random(200);

      set_bounds(2048, 2048, 8192, 8192, 16384);
      queue_item(zbpa_pkg::MODE_FREE, 0, TOP_ORDER, 1024);
      queue_item(zbpa_pkg::MODE_FREE, 0, TOP_ORDER, 2048);
      run_random(200);

      // gaps between the zones
      set_bounds(1000, 3000, 9000, 10000, 15000);
      queue_item(zbpa_pkg::MODE_FREE, 0, 0, 2000);
      queue_item(zbpa_pkg::MODE_FREE, 0, 15, 9500);
      queue_item(zbpa_pkg::MODE_FREE, 0, 0, FMASK);
      run_random(200);

      set_bounds(0, 0, 0, 0, 16384);
      run_random(200);

      set_bounds(16384, 16384, 16384, 16384, 16384);
      run_random(200);

      set_bounds(0, 0, 0, 0, 0);
      run_random(40);

      repeat (50) @(posedge clock);
      if (err_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

[files.f]
design/zbpa_pkg.sv
design/zbpa_ram.sv
design/zbpa_csr.sv
design/zbpa_ctrl.sv
design/zoned_buddy_page_allocator_unit.sv
verif/zoned_buddy_page_allocator_unit_tb.sv
